>>> hdl/stpq_pkg.sv
// Shared constants, codes and types of the sorted thread priority queue.
package stpq_pkg;

  localparam int DEPTH      = 64;
  localparam int ID_WIDTH   = 8;
  localparam int PRIO_WIDTH = 8;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_PUSH     = 2'd0,
    CMD_REMOVE   = 2'd1,
    CMD_PEEK     = 2'd2,
    CMD_SET_WAIT = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  // Contents of one queue slot.
  typedef struct packed {
    logic [PRIO_WIDTH-1:0] prio;
    logic [ID_WIDTH-1:0]   id;
    logic                  waiting;
  } cell_data_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic                  push_en;     // commit an insert this cycle
    logic                  remove_en;   // commit a delete this cycle
    logic                  set_wait_en; // commit a flag update this cycle
    logic                  peek;        // scan looks for a runnable entry
    logic                  force_hit;   // lone entry is returned regardless of flag
    logic [ID_WIDTH-1:0]   id;
    logic [PRIO_WIDTH-1:0] prio;
    logic                  waiting;
  } cell_ctrl_t;

endpackage

>>> hdl/stpq_cell.sv
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
module stpq_cell import stpq_pkg::*; (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic       occ_i,      // this slot holds an entry
  input  logic       left_occ_i, // left neighbor holds an entry (true left of slot 0)
  input  logic       front_i,    // scan token sits on this slot
  input  logic       mask_i,     // this slot is at or after the scan token
  input  cell_data_t left_i,
  input  cell_data_t right_i,
  output cell_data_t data_o,
  output logic       hit_o
);

  cell_data_t data_q, data_d;
  logic       left_lt, self_lt, cond;
  cell_data_t new_entry;

  // Local compare and next value
  always_comb begin
    new_entry.prio    = ctrl_i.prio;
    new_entry.id      = ctrl_i.id;
    new_entry.waiting = ctrl_i.waiting;
    left_lt = left_occ_i && (left_i.prio < ctrl_i.prio);
    self_lt = occ_i && (data_q.prio < ctrl_i.prio);
    data_d  = data_q;
    if (ctrl_i.push_en && (occ_i || left_occ_i)) begin
      // lower priorities move right; new entry lands after equal or higher ones
      if (left_lt) begin
        data_d = left_i;
      end else if (self_lt || !occ_i) begin
        data_d = new_entry;
      end
    end else if (ctrl_i.remove_en && mask_i && occ_i) begin
      data_d = right_i;
    end else if (ctrl_i.set_wait_en && front_i) begin
      data_d.waiting = ctrl_i.waiting;
    end
  end

  // Scan match
  always_comb begin
    if (ctrl_i.peek) begin
      cond = !data_q.waiting || ctrl_i.force_hit;
    end else begin
      cond = (data_q.id == ctrl_i.id);
    end
    hit_o = front_i && occ_i && cond;
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

>>> hdl/sorted_thread_priority_queue.sv
// Top level of the sorted thread priority queue: controller, scan token and cell chain.
//
// Entries sit in a chain of DEPTH cells kept sorted by descending priority, FIFO among
// equal priorities. A push compares every cell with its left neighbor at once and
// commits in the execute state without a token walk. Remove, peek and set-waiting
// send a scan token down the chain one cell per cycle until a match or a miss; any
// command waits in the execute state while the output register holds an unaccepted
// result. A new transaction is accepted while the previous result still waits in
// the output register. Slot contents are undefined after reset; only slots below the
// occupancy are ever read.
module sorted_thread_priority_queue import stpq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            command_i,
  input  logic [ID_WIDTH-1:0]   thread_id_i,
  input  logic [PRIO_WIDTH-1:0] prio_i,
  input  logic                  waiting_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            status_o,
  output logic [ID_WIDTH-1:0]   result_id_o,
  output logic [CNT_W-1:0]      occupancy_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e                state_q, state_d;
  cmd_e                  cmd_q;
  logic [ID_WIDTH-1:0]   id_q;
  logic [PRIO_WIDTH-1:0] prio_q;
  logic                  wait_q;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [DEPTH-1:0]      mask_q, mask_d;
  logic                  out_valid_q;
  status_e               status_q, status_d;
  logic [ID_WIDTH-1:0]   rid_q, rid_d;

  logic [DEPTH-1:0] occ, front, hit;
  cell_data_t       data  [DEPTH];
  cell_data_t       left_d[DEPTH];
  cell_data_t       right_d[DEPTH];
  logic [DEPTH-1:0] left_occ;
  cell_ctrl_t       ctrl;

  logic in_fire, exec, is_push, full, hit_any, miss, done, fire;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign exec       = (state_q == S_EXEC);
  assign is_push    = (cmd_q == CMD_PUSH);
  assign full       = (count_q == CNT_W'(DEPTH));
  assign hit_any    = |hit;
  assign miss       = ~|(front & occ);
  assign done       = is_push || hit_any || miss;
  assign fire       = exec && done && (!out_valid_q || out_ready_i);

  // Per-slot occupancy, token front and neighbor wiring
  for (genvar k = 0; k < DEPTH; k++) begin : g_chain
    assign occ[k] = (count_q > CNT_W'(k));
    if (k == 0) begin : g_first
      assign front[k]    = mask_q[k];
      assign left_occ[k] = 1'b1;
      assign left_d[k]   = '{prio: '1, id: '0, waiting: 1'b0};
    end else begin : g_rest
      assign front[k]    = mask_q[k] & ~mask_q[k-1];
      assign left_occ[k] = occ[k-1];
      assign left_d[k]   = data[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_d[k] = '0;
    end else begin : g_inner
      assign right_d[k] = data[k+1];
    end

    stpq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occ_i      (occ[k]),
      .left_occ_i (left_occ[k]),
      .front_i    (front[k]),
      .mask_i     (mask_q[k]),
      .left_i     (left_d[k]),
      .right_i    (right_d[k]),
      .data_o     (data[k]),
      .hit_o      (hit[k])
    );
  end

  // Broadcast control; commits only on the finishing cycle
  always_comb begin
    ctrl.push_en     = fire && is_push && !full;
    ctrl.remove_en   = fire && (cmd_q == CMD_REMOVE) && hit_any;
    ctrl.set_wait_en = fire && (cmd_q == CMD_SET_WAIT) && hit_any;
    ctrl.peek        = (cmd_q == CMD_PEEK);
    ctrl.force_hit   = (count_q == CNT_W'(1));
    ctrl.id          = id_q;
    ctrl.prio        = prio_q;
    ctrl.waiting     = wait_q;
  end

  // Id of the hit slot, reported for peek only (token is one-hot, so an OR suffices)
  always_comb begin
    rid_d = '0;
    for (int k = 0; k < DEPTH; k++) begin
      if (hit[k]) begin
        rid_d = rid_d | data[k].id;
      end
    end
    if (cmd_q != CMD_PEEK) begin
      rid_d = '0;
    end
  end

  // Status and occupancy update
  always_comb begin
    count_d = count_q;
    if (is_push) begin
      status_d = full ? ST_FULL : ST_OK;
    end else begin
      status_d = hit_any ? ST_OK : ST_MISS;
    end
    if (ctrl.push_en) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctrl.remove_en) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // Sequencer and token advance
  always_comb begin
    state_d = state_q;
    mask_d  = mask_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_EXEC;
          mask_d  = '1;
        end
      end
      S_EXEC: begin
        if (fire) begin
          state_d = S_IDLE;
        end else if (!done) begin
          mask_d = mask_q << 1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      mask_q  <= mask_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Transaction and result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= cmd_e'(command_i);
      id_q   <= thread_id_i;
      prio_q <= prio_i;
      wait_q <= waiting_i;
    end
    if (fire) begin
      status_q    <= status_d;
      rid_q       <= rid_d;
      occupancy_o <= count_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign result_id_o = rid_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("occupancy above depth");

  a_front_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |-> $onehot0(front))
    else $error("scan token not at a single slot");

  a_hit_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit))
    else $error("more than one slot hit");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && is_push && !full) |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("push did not grow the queue");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_EXEC) && (mask_q == '1))
    else $error("accepted transaction did not start a scan");
`endif

endmodule

>>> tb/tb_sorted_thread_priority_queue.sv
// Self-checking testbench for the sorted thread priority queue.
`timescale 1ns / 100ps

module tb_sorted_thread_priority_queue;
  import stpq_pkg::*;

  localparam int RANDOM_ITEMS = 1225;
  localparam int MAX_DELAY    = 13;
  localparam int SETTLE_CYCLES = DEPTH + 8;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int MAX_REPORTS  = 10;

  typedef enum int {
    PHASE_FILL,
    PHASE_DRAIN,
    PHASE_MIX
  } traffic_phase_e;

  // One expected response of the queue.
  typedef struct {
    status_e             status;
    logic [ID_WIDTH-1:0] result_id;
    logic [CNT_W-1:0]    occupancy;
  } queue_result_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [1:0]            command_i   = CMD_PEEK;
  logic [ID_WIDTH-1:0]   thread_id_i = '0;
  logic [PRIO_WIDTH-1:0] prio_i      = '0;
  logic                  waiting_i   = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [1:0]            status_o;
  logic [ID_WIDTH-1:0]   result_id_o;
  logic [CNT_W-1:0]      occupancy_o;

  // Shadow copy of the sorted entry chain
  logic [PRIO_WIDTH-1:0] shadow_prio [DEPTH];
  logic [ID_WIDTH-1:0]   shadow_id   [DEPTH];
  logic                  shadow_wait [DEPTH];
  int                    shadow_count = 0;

  queue_result_t expected_results[$];
  int            mismatch_count = 0;
  int unsigned   cycle_count    = 0;
  bit            steady_flow    = 1'b0;

  sorted_thread_priority_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .thread_id_i (thread_id_i),
    .prio_i      (prio_i),
    .waiting_i   (waiting_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .result_id_o (result_id_o),
    .occupancy_o (occupancy_o)
  );

  always #10 clk_i = ~clk_i;

  // Run watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_sorted_thread_priority_queue failed");
      $finish;
    end
  end

  function automatic int draw_delay();
    return steady_flow ? 0 : $urandom_range(0, MAX_DELAY);
  endfunction

  function automatic logic [ID_WIDTH-1:0] any_id();
    return ID_WIDTH'($urandom);
  endfunction

  function automatic logic [PRIO_WIDTH-1:0] any_prio();
    return PRIO_WIDTH'($urandom);
  endfunction

  // Position of the first entry with this id, -1 when absent.
  function automatic int find_thread(logic [ID_WIDTH-1:0] id);
    int pos;
    pos = -1;
    for (int k = shadow_count - 1; k >= 0; k--) begin
      if (shadow_id[k] == id) pos = k;
    end
    return pos;
  endfunction

  // Applies one command to the shadow chain and returns the response it should give.
  function automatic queue_result_t predict_queue(cmd_e cmd, logic [ID_WIDTH-1:0] id,
                                                  logic [PRIO_WIDTH-1:0] prio, logic waiting);
    queue_result_t res;
    int            k;
    int            hit;
    res.status    = ST_OK;
    res.result_id = '0;
    case (cmd)
      CMD_PUSH: begin
        if (shadow_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          // insert behind every entry of equal or higher priority
          k = shadow_count;
          while (k > 0 && shadow_prio[k-1] < prio) begin
            shadow_prio[k] = shadow_prio[k-1];
            shadow_id[k]   = shadow_id[k-1];
            shadow_wait[k] = shadow_wait[k-1];
            k--;
          end
          shadow_prio[k] = prio;
          shadow_id[k]   = id;
          shadow_wait[k] = waiting;
          shadow_count++;
        end
      end
      CMD_REMOVE: begin
        hit = find_thread(id);
        if (hit < 0) begin
          res.status = ST_MISS;
        end else begin
          for (k = hit; k < shadow_count - 1; k++) begin
            shadow_prio[k] = shadow_prio[k+1];
            shadow_id[k]   = shadow_id[k+1];
            shadow_wait[k] = shadow_wait[k+1];
          end
          shadow_count--;
        end
      end
      CMD_PEEK: begin
        if (shadow_count == 0) begin
          res.status = ST_MISS;
        end else if (shadow_count == 1) begin
          // a lone entry is served even while waiting
          res.result_id = shadow_id[0];
        end else begin
          res.status = ST_MISS;
          for (k = shadow_count - 1; k >= 0; k--) begin
            if (!shadow_wait[k]) begin
              res.status    = ST_OK;
              res.result_id = shadow_id[k];
            end
          end
        end
      end
      default: begin
        hit = find_thread(id);
        if (hit < 0) res.status = ST_MISS;
        else shadow_wait[hit] = waiting;
      end
    endcase
    res.occupancy = CNT_W'(shadow_count);
    return res;
  endfunction

  // Drives one command transaction and records its expected response on acceptance.
  task automatic send_item(cmd_e cmd, logic [ID_WIDTH-1:0] id,
                           logic [PRIO_WIDTH-1:0] prio, logic waiting);
    int gap;
    gap = draw_delay();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    thread_id_i <= id;
    prio_i      <= prio;
    waiting_i   <= waiting;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results.push_back(predict_queue(cmd, id, prio, waiting));
  endtask

  // Result sink with random back-pressure
  initial begin : result_sink
    int stall;
    forever begin
      stall = draw_delay();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // Compare each response transaction with the oldest expectation
  always @(posedge clk_i) begin
    queue_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected response status %0d id %0d occupancy %0d",
                   $time, status_o, result_id_o, occupancy_o);
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status || result_id_o !== want.result_id ||
            occupancy_o !== want.occupancy) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: expected status %0d id %0d occupancy %0d, got %0d %0d %0d",
                     $time, want.status, want.result_id, want.occupancy,
                     status_o, result_id_o, occupancy_o);
        end
      end
    end
  end

  // Peek, remove and set-waiting against an empty queue all miss
  task automatic test_empty_queue();
    send_item(CMD_PEEK, any_id(), any_prio(), 1'($urandom));
    send_item(CMD_REMOVE, any_id(), any_prio(), 1'($urandom));
    send_item(CMD_SET_WAIT, any_id(), any_prio(), 1'($urandom));
  endtask

  // Lone waiting entry, all entries waiting, flag cleared again
  task automatic test_peek_rules();
    send_item(CMD_PUSH, '0, '0, 1'b1);
    send_item(CMD_PEEK, any_id(), any_prio(), 1'($urandom));
    send_item(CMD_PUSH, '1, '1, 1'b1);
    send_item(CMD_PEEK, any_id(), any_prio(), 1'($urandom));
    send_item(CMD_SET_WAIT, '0, any_prio(), 1'b0);
    send_item(CMD_PEEK, any_id(), any_prio(), 1'($urandom));
    send_item(CMD_REMOVE, '1, any_prio(), 1'($urandom));
    send_item(CMD_REMOVE, '0, any_prio(), 1'($urandom));
  endtask

  // FIFO among equal priorities, duplicate ids, absent ids
  task automatic test_duplicates_and_order();
    send_item(CMD_PUSH, 8'hAA, 8'h80, 1'b0);
    send_item(CMD_PUSH, 8'hAA, 8'h80, 1'b1);
    send_item(CMD_PUSH, 8'h01, 8'h80, 1'b0);
    send_item(CMD_PUSH, 8'h33, 8'h81, 1'b1);
    send_item(CMD_PEEK, any_id(), any_prio(), 1'($urandom));
    send_item(CMD_SET_WAIT, 8'hAA, any_prio(), 1'b1);
    send_item(CMD_PEEK, any_id(), any_prio(), 1'($urandom));
    send_item(CMD_SET_WAIT, 8'h5C, any_prio(), 1'b0);
    send_item(CMD_REMOVE, 8'hAA, any_prio(), 1'($urandom));
    send_item(CMD_PEEK, any_id(), any_prio(), 1'($urandom));
    send_item(CMD_REMOVE, 8'h77, any_prio(), 1'($urandom));
    send_item(CMD_REMOVE, 8'h01, any_prio(), 1'($urandom));
    send_item(CMD_REMOVE, 8'hAA, any_prio(), 1'($urandom));
    send_item(CMD_REMOVE, 8'h33, any_prio(), 1'($urandom));
  endtask

  // Phased random traffic: push-heavy fill, remove-heavy drain, mixed
  task automatic test_random_traffic();
    traffic_phase_e        phase;
    int                    phase_len;
    int                    wait_pct;
    int                    roll;
    int                    sent;
    bit                    narrow_prio;
    cmd_e                  cmd;
    logic [ID_WIDTH-1:0]   id;
    logic [PRIO_WIDTH-1:0] prio;
    logic                  waiting;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase       = traffic_phase_e'($urandom_range(0, 2));
      phase_len   = $urandom_range(40, 150);
      // last phase stops at the item budget
      if (phase_len > RANDOM_ITEMS - sent) phase_len = RANDOM_ITEMS - sent;
      wait_pct    = $urandom_range(5, 95);
      narrow_prio = 1'($urandom);
      steady_flow = ($urandom_range(0, 3) == 0);
      repeat (phase_len) begin
        roll = $urandom_range(0, 99);
        case (phase)
          PHASE_FILL:
            cmd = (roll < 80) ? CMD_PUSH : (roll < 87) ? CMD_PEEK :
                  (roll < 94) ? CMD_SET_WAIT : CMD_REMOVE;
          PHASE_DRAIN:
            cmd = (roll < 60) ? CMD_REMOVE : (roll < 75) ? CMD_PEEK :
                  (roll < 88) ? CMD_SET_WAIT : CMD_PUSH;
          default:
            cmd = cmd_e'($urandom_range(0, 3));
        endcase
        // mostly target held ids, otherwise a small pool for duplicates or any id
        if ((cmd == CMD_REMOVE || cmd == CMD_SET_WAIT) && shadow_count != 0 &&
            $urandom_range(0, 3) != 0)
          id = shadow_id[$urandom_range(0, shadow_count - 1)];
        else if ($urandom_range(0, 1) != 0)
          id = ID_WIDTH'($urandom_range(0, 15));
        else
          id = any_id();
        // narrow priorities give many ties
        if (narrow_prio)
          prio = ($urandom_range(0, 1) != 0) ? PRIO_WIDTH'($urandom_range(0, 3)) :
                 ~PRIO_WIDTH'($urandom_range(0, 3));
        else
          prio = any_prio();
        waiting = ($urandom_range(0, 99) < wait_pct);
        send_item(cmd, id, prio, waiting);
        sent++;
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin : run_tests
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_queue();
    test_peek_rules();
    test_duplicates_and_order();
    test_random_traffic();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb_sorted_thread_priority_queue passed");
    end else begin
      $display("tb_sorted_thread_priority_queue failed");
    end
    $finish;
  end

endmodule
